FILE: hw/rtl/display_command_frame_sender_core_defines.svh
// Assertion macros shared by the frame sender modules.
`ifndef DISPLAY_COMMAND_FRAME_SENDER_CORE_DEFINES_SVH
`define DISPLAY_COMMAND_FRAME_SENDER_CORE_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define DCFS_ASSERT_SAME(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define DCFS_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

FILE: hw/rtl/dcfs_pkg.sv
// Types and constants shared by the display command frame sender.
package dcfs_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int INDEX_WIDTH = $clog2(MAX_PAYLOAD);
   localparam int COUNT_WIDTH = 6;
   localparam int WORD_WIDTH  = 8;
   localparam int ADDR_WIDTH  = 7;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [WORD_WIDTH-1:0] WORD_DC1        = 8'd17;
   localparam logic [WORD_WIDTH-1:0] WORD_ESC        = 8'd27;
   localparam logic [WORD_WIDTH-1:0] RESEND_CODE     = 8'd15;
   localparam logic [WORD_WIDTH-1:0] LENGTH_OVERHEAD = 8'd3;
   localparam logic [WORD_WIDTH-1:0] REQ_START       = 8'd0;
   localparam logic [WORD_WIDTH-1:0] REQ_COUNT       = 8'd1;

   localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;

   typedef enum logic [1:0] {
      OP_BEGIN    = 2'd0,
      OP_PAYLOAD  = 2'd1,
      OP_RESPONSE = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COUNT,
      ST_ADDRESS,
      ST_DC1,
      ST_LENGTH,
      ST_ESC,
      ST_CMD_FIRST,
      ST_CMD_SECOND,
      ST_ECHO,
      ST_REPLAY,
      ST_SUM,
      ST_REQ_START,
      ST_REQ_ADDRESS,
      ST_REQ_COUNT
   } state_type;

   typedef struct packed {
      logic      start_frame;
      logic      take_payload;
      logic      end_frame;
      logic      start_resend;
      logic      tail_sent;
      logic      advance_replay;
      logic      load_word;
      logic      last_word;
      state_type word_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic awaiting;
      logic payload_open;
      logic frame_full;
      logic count_zero;
      logic replay_end;
      logic resend_code;
   } dp_status_type;

endpackage

FILE: hw/rtl/dcfs_datapath.sv
// Frame sender datapath: frame state, payload buffer, word mux and output register.
`include "display_command_frame_sender_core_defines.svh"

module dcfs_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  dcfs_pkg::ctrl_cmd_type                   cmd,
   output dcfs_pkg::dp_status_type                  status,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]          req_command_first,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]          req_command_second,
   input  logic [dcfs_pkg::COUNT_WIDTH-1:0]         req_payload_count,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]          req_data_byte,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [dcfs_pkg::WORD_WIDTH-1:0]          rsp_bus_word,
   output logic                                     rsp_frame_last,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [dcfs_pkg::CSR_ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [dcfs_pkg::CSR_DATA_WIDTH-1:0]      csr_pwdata,
   output logic [dcfs_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   logic [dcfs_pkg::WORD_WIDTH-1:0]  payload_mem [dcfs_pkg::MAX_PAYLOAD];
   logic [dcfs_pkg::WORD_WIDTH-1:0]  rd_data_ff;
   logic [dcfs_pkg::INDEX_WIDTH-1:0] rd_addr;

   logic [dcfs_pkg::COUNT_WIDTH-1:0] expected_ff, expected_in;
   logic [dcfs_pkg::COUNT_WIDTH-1:0] received_ff, received_in;
   logic [dcfs_pkg::COUNT_WIDTH-1:0] replay_idx_ff, replay_idx_in;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  cmd_first_ff, cmd_first_in;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  cmd_second_ff, cmd_second_in;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  sum_ff, sum_in;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  echo_ff;
   logic                             awaiting_ff, awaiting_in;
   logic [dcfs_pkg::ADDR_WIDTH-1:0]  device_addr_ff, device_addr_in;
   logic                             out_valid_ff, out_valid_in;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  out_word_ff;
   logic                             out_last_ff;

   logic [dcfs_pkg::COUNT_WIDTH-1:0] count_sat;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  begin_sum;
   logic [dcfs_pkg::WORD_WIDTH-1:0]  word_mux;
   logic                             csr_write;

   assign count_sat = (req_payload_count > dcfs_pkg::COUNT_WIDTH'(dcfs_pkg::MAX_PAYLOAD))
                      ? dcfs_pkg::COUNT_WIDTH'(dcfs_pkg::MAX_PAYLOAD) : req_payload_count;

   assign begin_sum = dcfs_pkg::WORD_DC1 + dcfs_pkg::WORD_WIDTH'(count_sat)
                      + dcfs_pkg::LENGTH_OVERHEAD + dcfs_pkg::WORD_ESC
                      + req_command_first + req_command_second;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == dcfs_pkg::REG_DEVICE_ADDRESS)
                       ? dcfs_pkg::CSR_DATA_WIDTH'(device_addr_ff) : '0;

   always_comb begin
      device_addr_in = device_addr_ff;
      if (csr_write && csr_paddr[2] == dcfs_pkg::REG_DEVICE_ADDRESS) begin
         device_addr_in = csr_pwdata[dcfs_pkg::ADDR_WIDTH-1:0];
      end
   end

   always_comb begin
      expected_in   = expected_ff;
      received_in   = received_ff;
      cmd_first_in  = cmd_first_ff;
      cmd_second_in = cmd_second_ff;
      sum_in        = sum_ff;
      awaiting_in   = awaiting_ff;
      replay_idx_in = replay_idx_ff;
      if (cmd.start_frame) begin
         expected_in   = count_sat;
         received_in   = '0;
         cmd_first_in  = req_command_first;
         cmd_second_in = req_command_second;
         sum_in        = begin_sum;
         awaiting_in   = 1'b0;
      end
      if (cmd.take_payload) begin
         received_in = received_ff + dcfs_pkg::COUNT_WIDTH'(1);
         sum_in      = sum_ff + req_data_byte;
      end
      if (cmd.end_frame) begin
         awaiting_in = 1'b0;
         expected_in = '0;
         received_in = '0;
      end
      if (cmd.tail_sent) begin
         awaiting_in = 1'b1;
      end
      if (cmd.start_resend) begin
         replay_idx_in = '0;
      end
      if (cmd.advance_replay) begin
         replay_idx_in = replay_idx_ff + dcfs_pkg::COUNT_WIDTH'(1);
      end
   end

   assign rd_addr = replay_idx_in[dcfs_pkg::INDEX_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.take_payload) begin
         payload_mem[received_ff[dcfs_pkg::INDEX_WIDTH-1:0]] <= req_data_byte;
      end
      rd_data_ff <= payload_mem[rd_addr];
   end

   always_comb begin
      unique case (cmd.word_sel)
         dcfs_pkg::ST_COUNT:       word_mux = dcfs_pkg::WORD_WIDTH'(expected_ff)
                                              + dcfs_pkg::LENGTH_OVERHEAD + 8'd3;
         dcfs_pkg::ST_ADDRESS:     word_mux = {device_addr_ff, 1'b0};
         dcfs_pkg::ST_DC1:         word_mux = dcfs_pkg::WORD_DC1;
         dcfs_pkg::ST_LENGTH:      word_mux = dcfs_pkg::WORD_WIDTH'(expected_ff)
                                              + dcfs_pkg::LENGTH_OVERHEAD;
         dcfs_pkg::ST_ESC:         word_mux = dcfs_pkg::WORD_ESC;
         dcfs_pkg::ST_CMD_FIRST:   word_mux = cmd_first_ff;
         dcfs_pkg::ST_CMD_SECOND:  word_mux = cmd_second_ff;
         dcfs_pkg::ST_ECHO:        word_mux = echo_ff;
         dcfs_pkg::ST_REPLAY:      word_mux = rd_data_ff;
         dcfs_pkg::ST_SUM:         word_mux = sum_ff;
         dcfs_pkg::ST_REQ_START:   word_mux = dcfs_pkg::REQ_START;
         dcfs_pkg::ST_REQ_ADDRESS: word_mux = {device_addr_ff, 1'b1};
         dcfs_pkg::ST_REQ_COUNT:   word_mux = dcfs_pkg::REQ_COUNT;
         default:                  word_mux = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_word) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff    <= '0;
         received_ff    <= '0;
         cmd_first_ff   <= '0;
         cmd_second_ff  <= '0;
         sum_ff         <= '0;
         awaiting_ff    <= 1'b0;
         replay_idx_ff  <= '0;
         device_addr_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         expected_ff    <= expected_in;
         received_ff    <= received_in;
         cmd_first_ff   <= cmd_first_in;
         cmd_second_ff  <= cmd_second_in;
         sum_ff         <= sum_in;
         awaiting_ff    <= awaiting_in;
         replay_idx_ff  <= replay_idx_in;
         device_addr_ff <= device_addr_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_payload) begin
         echo_ff <= req_data_byte;
      end
      if (cmd.load_word) begin
         out_word_ff <= word_mux;
         out_last_ff <= cmd.last_word;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_bus_word   = out_word_ff;
   assign rsp_frame_last = out_last_ff;

   assign status.out_free     = ~out_valid_ff | rsp_ready;
   assign status.awaiting     = awaiting_ff;
   assign status.payload_open = ~awaiting_ff & (received_ff < expected_ff);
   assign status.frame_full   = (received_ff == expected_ff);
   assign status.count_zero   = (expected_ff == '0);
   assign status.replay_end   = (replay_idx_ff + dcfs_pkg::COUNT_WIDTH'(1)) == expected_ff;
   assign status.resend_code  = (req_data_byte == dcfs_pkg::RESEND_CODE);

   `DCFS_ASSERT_SAME(a_received_bounded, clock, reset, 1'b1, received_ff <= expected_ff,
                     "received count passed expected count")
   `DCFS_ASSERT_SAME(a_expected_bounded, clock, reset, 1'b1,
                     expected_ff <= dcfs_pkg::COUNT_WIDTH'(dcfs_pkg::MAX_PAYLOAD),
                     "expected count above buffer depth")
   `DCFS_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_word, out_valid_ff,
                     "loaded word not presented")

endmodule

FILE: hw/rtl/dcfs_ctrl.sv
// Frame sender controller: input decode and word sequencing state machine.
`include "display_command_frame_sender_core_defines.svh"

module dcfs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  dcfs_pkg::dp_status_type    status,
   output dcfs_pkg::ctrl_cmd_type     cmd
);

   dcfs_pkg::state_type state_ff, state_in;
   logic                replay_ff, replay_in;
   logic                accept;
   logic                emit;

   assign req_ready = (state_ff == dcfs_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign emit      = (state_ff != dcfs_pkg::ST_IDLE) & status.out_free;

   always_comb begin
      state_in  = state_ff;
      replay_in = replay_ff;
      unique case (state_ff)
         dcfs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  dcfs_pkg::OP_BEGIN: begin
                     state_in  = dcfs_pkg::ST_COUNT;
                     replay_in = 1'b0;
                  end
                  dcfs_pkg::OP_PAYLOAD: begin
                     if (status.payload_open) begin
                        state_in = dcfs_pkg::ST_ECHO;
                     end
                  end
                  dcfs_pkg::OP_RESPONSE: begin
                     if (status.awaiting && status.resend_code) begin
                        state_in  = dcfs_pkg::ST_COUNT;
                        replay_in = 1'b1;
                     end
                  end
                  default: state_in = dcfs_pkg::ST_IDLE;
               endcase
            end
         end
         dcfs_pkg::ST_COUNT:     if (emit) state_in = dcfs_pkg::ST_ADDRESS;
         dcfs_pkg::ST_ADDRESS:   if (emit) state_in = dcfs_pkg::ST_DC1;
         dcfs_pkg::ST_DC1:       if (emit) state_in = dcfs_pkg::ST_LENGTH;
         dcfs_pkg::ST_LENGTH:    if (emit) state_in = dcfs_pkg::ST_ESC;
         dcfs_pkg::ST_ESC:       if (emit) state_in = dcfs_pkg::ST_CMD_FIRST;
         dcfs_pkg::ST_CMD_FIRST: if (emit) state_in = dcfs_pkg::ST_CMD_SECOND;
         dcfs_pkg::ST_CMD_SECOND: begin
            if (emit) begin
               if (status.count_zero) begin
                  state_in = dcfs_pkg::ST_SUM;
               end else if (replay_ff) begin
                  state_in = dcfs_pkg::ST_REPLAY;
               end else begin
                  state_in = dcfs_pkg::ST_IDLE;
               end
            end
         end
         dcfs_pkg::ST_ECHO: begin
            if (emit) begin
               state_in = status.frame_full ? dcfs_pkg::ST_SUM : dcfs_pkg::ST_IDLE;
            end
         end
         dcfs_pkg::ST_REPLAY: begin
            if (emit && status.replay_end) begin
               state_in = dcfs_pkg::ST_SUM;
            end
         end
         dcfs_pkg::ST_SUM:         if (emit) state_in = dcfs_pkg::ST_REQ_START;
         dcfs_pkg::ST_REQ_START:   if (emit) state_in = dcfs_pkg::ST_REQ_ADDRESS;
         dcfs_pkg::ST_REQ_ADDRESS: if (emit) state_in = dcfs_pkg::ST_REQ_COUNT;
         dcfs_pkg::ST_REQ_COUNT:   if (emit) state_in = dcfs_pkg::ST_IDLE;
         default:                  state_in = dcfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd                = '0;
      cmd.word_sel       = state_ff;
      cmd.load_word      = emit;
      cmd.advance_replay = emit && (state_ff == dcfs_pkg::ST_REPLAY);
      cmd.tail_sent      = emit && (state_ff == dcfs_pkg::ST_REQ_COUNT);
      unique case (state_ff)
         dcfs_pkg::ST_CMD_SECOND: cmd.last_word = ~replay_ff & ~status.count_zero;
         dcfs_pkg::ST_ECHO:       cmd.last_word = ~status.frame_full;
         dcfs_pkg::ST_REQ_COUNT:  cmd.last_word = 1'b1;
         default:                 cmd.last_word = 1'b0;
      endcase
      if (accept) begin
         case (req_operation)
            dcfs_pkg::OP_BEGIN:    cmd.start_frame  = 1'b1;
            dcfs_pkg::OP_PAYLOAD:  cmd.take_payload = status.payload_open;
            dcfs_pkg::OP_RESPONSE: begin
               cmd.start_resend = status.awaiting & status.resend_code;
               cmd.end_frame    = status.awaiting & ~status.resend_code;
            end
            default: cmd.start_frame = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dcfs_pkg::ST_IDLE;
         replay_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         replay_ff <= replay_in;
      end
   end

   `DCFS_ASSERT_NEXT(a_tail_sets_await, clock, reset, cmd.tail_sent, status.awaiting,
                     "acknowledge request sent without awaiting response")
   `DCFS_ASSERT_SAME(a_replay_has_payload, clock, reset, state_ff == dcfs_pkg::ST_REPLAY,
                     !status.count_zero, "replay with empty payload")
   `DCFS_ASSERT_NEXT(a_echo_after_payload, clock, reset, cmd.take_payload,
                     state_ff == dcfs_pkg::ST_ECHO, "payload byte taken but not echoed")

endmodule

FILE: hw/rtl/display_command_frame_sender_core.sv
// Top level of the display command frame sender.
//
//   channel   direction  handshake                    payload
//   req_      in         req_valid / req_ready        operation, command_first/second,
//                                                     payload_count, data_byte
//   rsp_      out        rsp_valid / rsp_ready        bus_word, frame_last
//   csr_      in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item is taken while idle; it then emits its run, if any, at one word per
// cycle while rsp_ready allows, from a single output register. The next item
// is taken once the last word is loaded. Replay reads the payload buffer one
// entry per cycle while rsp_ready allows, via a registered read fetched ahead.
// Synchronous active-high reset clears all frame state; no clearing pass.
module display_command_frame_sender_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_operation,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]       req_command_first,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]       req_command_second,
   input  logic [dcfs_pkg::COUNT_WIDTH-1:0]      req_payload_count,
   input  logic [dcfs_pkg::WORD_WIDTH-1:0]       req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dcfs_pkg::WORD_WIDTH-1:0]       rsp_bus_word,
   output logic                                  rsp_frame_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dcfs_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [dcfs_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [dcfs_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   dcfs_pkg::ctrl_cmd_type  cmd;
   dcfs_pkg::dp_status_type status;

   dcfs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   dcfs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_command_first  (req_command_first),
      .req_command_second (req_command_second),
      .req_payload_count  (req_payload_count),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bus_word       (rsp_bus_word),
      .rsp_frame_last     (rsp_frame_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the display command frame sender core.
`timescale 1ns / 100ps

module tb_top;
   import dcfs_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [WORD_WIDTH-1:0] BRIDGE_EXTRA = 8'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] DEV_ADDR_OFFSET =
      CSR_ADDR_WIDTH'(REG_DEVICE_ADDRESS) << 2;
   localparam int SETTLE_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AT = 400;
   localparam int ITEMS_PER_PHASE = 85;

   typedef struct {
      logic [1:0]             op;
      logic [WORD_WIDTH-1:0]  cmd_first;
      logic [WORD_WIDTH-1:0]  cmd_second;
      logic [COUNT_WIDTH-1:0] count;
      logic [WORD_WIDTH-1:0]  data;
      bit                     drain;
   } frame_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic                  last;
   } bus_word_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = '0;
   logic [WORD_WIDTH-1:0] req_command_first = '0;
   logic [WORD_WIDTH-1:0] req_command_second = '0;
   logic [COUNT_WIDTH-1:0] req_payload_count = '0;
   logic [WORD_WIDTH-1:0] req_data_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_bus_word;
   logic rsp_frame_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // frame state mirror
   logic [ADDR_WIDTH-1:0]  addr_cfg = '0;
   logic [WORD_WIDTH-1:0]  payload_buf [0:MAX_PAYLOAD-1];
   logic [COUNT_WIDTH-1:0] frame_len = '0;
   logic [COUNT_WIDTH-1:0] bytes_in = '0;
   logic [WORD_WIDTH-1:0]  cmd_first_held = '0;
   logic [WORD_WIDTH-1:0]  cmd_second_held = '0;
   logic [WORD_WIDTH-1:0]  checksum = '0;
   logic                   reply_pending = 1'b0;
   logic [WORD_WIDTH-1:0]  run_words [$];

   frame_req_type pending_reqs [$];
   bus_word_type  bus_words_due [$];
   frame_req_type req_cur;
   logic req_taken = 1'b0;
   int unsigned req_gap_left = 0;
   int unsigned req_steady_left = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_steady_left = 0;
   int unsigned hold_left = 0;
   bit hold_done = 0;
   int unsigned words_seen = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned items_queued = 0;

   display_command_frame_sender_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_command_first  (req_command_first),
      .req_command_second (req_command_second),
      .req_payload_count  (req_payload_count),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bus_word       (rsp_bus_word),
      .rsp_frame_last     (rsp_frame_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 1;
      if (r < 88) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] rnd8();
      return WORD_WIDTH'($urandom_range(0, 255));
   endfunction

   function automatic void add_header();
      run_words.push_back(8'(frame_len) + LENGTH_OVERHEAD + BRIDGE_EXTRA);
      run_words.push_back({addr_cfg, 1'b0});
      run_words.push_back(WORD_DC1);
      run_words.push_back(8'(frame_len) + LENGTH_OVERHEAD);
      run_words.push_back(WORD_ESC);
      run_words.push_back(cmd_first_held);
      run_words.push_back(cmd_second_held);
   endfunction

   function automatic void add_tail();
      run_words.push_back(checksum);
      run_words.push_back(REQ_START);
      run_words.push_back({addr_cfg, 1'b1});
      run_words.push_back(REQ_COUNT);
      reply_pending = 1'b1;
   endfunction

   function automatic void predict_bus_words(input frame_req_type it);
      logic [COUNT_WIDTH-1:0] len;
      bus_word_type w;
      run_words.delete();
      case (it.op)
         OP_BEGIN: begin
            len = (it.count > MAX_PAYLOAD) ? COUNT_WIDTH'(MAX_PAYLOAD) : it.count;
            frame_len = len;
            bytes_in = '0;
            cmd_first_held = it.cmd_first;
            cmd_second_held = it.cmd_second;
            reply_pending = 1'b0;
            checksum = WORD_DC1 + 8'(len) + LENGTH_OVERHEAD + WORD_ESC + it.cmd_first
                       + it.cmd_second;
            add_header();
            if (len == 0) add_tail();
         end
         OP_PAYLOAD: begin
            if (!reply_pending && bytes_in < frame_len) begin
               payload_buf[bytes_in] = it.data;
               bytes_in = bytes_in + 1'b1;
               checksum = checksum + it.data;
               run_words.push_back(it.data);
               if (bytes_in == frame_len) add_tail();
            end
         end
         OP_RESPONSE: begin
            if (reply_pending) begin
               if (it.data == RESEND_CODE) begin
                  add_header();
                  for (int i = 0; i < frame_len; i++) run_words.push_back(payload_buf[i]);
                  add_tail();
               end else begin
                  reply_pending = 1'b0;
                  frame_len = '0;
                  bytes_in = '0;
               end
            end
         end
         default: ;
      endcase
      foreach (run_words[i]) begin
         w.word = run_words[i];
         w.last = (i == run_words.size() - 1);
         bus_words_due.push_back(w);
      end
   endfunction

   function automatic void flag_word(input string what, input bus_word_type exp_w);
      if (mismatches < 10)
         $display("%0t: %s: expected word %0d last %0b, got word %0d last %0b",
                  $time, what, exp_w.word, exp_w.last, rsp_bus_word, rsp_frame_last);
      mismatches++;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until transfer
      end else if (req_gap_left > 0) begin
         req_valid <= 1'b0;
         req_gap_left--;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain && bus_words_due.size() > 0)) begin
         req_cur = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_operation <= req_cur.op;
         req_command_first <= req_cur.cmd_first;
         req_command_second <= req_cur.cmd_second;
         req_payload_count <= req_cur.count;
         req_data_byte <= req_cur.data;
         if (req_steady_left > 0) begin
            req_steady_left--;
         end else if ($urandom_range(0, 99) < 4) begin
            req_steady_left = $urandom_range(30, 100);
         end else if ($urandom_range(0, 99) < 40) begin
            req_gap_left = pick_gap();
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && words_seen >= LONG_HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         hold_done = 1;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_steady_left > 0) begin
            rsp_steady_left--;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_steady_left = $urandom_range(30, 120);
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_stall_left = pick_gap();
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      bus_word_type exp_w;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (bus_words_due.size() == 0) begin
               exp_w = '0;
               flag_word("unexpected word", exp_w);
            end else begin
               exp_w = bus_words_due.pop_front();
               if (rsp_bus_word !== exp_w.word || rsp_frame_last !== exp_w.last)
                  flag_word("word mismatch", exp_w);
            end
         end
         if (req_valid && req_ready) predict_bus_words(req_cur);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     bus_words_due.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [1:0] op, input logic [WORD_WIDTH-1:0] c0,
                            input logic [WORD_WIDTH-1:0] c1,
                            input logic [COUNT_WIDTH-1:0] cnt,
                            input logic [WORD_WIDTH-1:0] dat, input bit drain,
                            input bit ignored);
      frame_req_type it;
      it.op = op;
      it.cmd_first = c0;
      it.cmd_second = c1;
      it.count = cnt;
      it.data = dat;
      it.drain = drain;
      pending_reqs.push_back(it);
      if (!ignored) items_queued++;
   endtask

   task automatic push_noise();
      int unsigned r;
      r = $urandom_range(0, 2);
      if (r == 0) push_item(OP_UNUSED, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 1);
      else if (r == 1) push_item(OP_RESPONSE, rnd8(), rnd8(), 6'($urandom_range(0, 63)),
                                 rnd8(), 0, 1);
      else push_item(OP_PAYLOAD, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 1);
   endtask

   task automatic close_frame();
      logic [WORD_WIDTH-1:0] v;
      do v = rnd8(); while (v == RESEND_CODE);
      push_item(OP_RESPONSE, rnd8(), rnd8(), 6'($urandom_range(0, 63)), v, 0, 0);
   endtask

   task automatic queue_frame(input bit drain);
      int unsigned r;
      int unsigned len;
      int unsigned cut;
      int unsigned resends;
      logic [COUNT_WIDTH-1:0] cnt;
      r = $urandom_range(0, 99);
      if (r < 60) cnt = 6'($urandom_range(0, 6));
      else if (r < 85) cnt = 6'($urandom_range(7, 31));
      else if (r < 95) cnt = 6'(MAX_PAYLOAD);
      else cnt = 6'($urandom_range(33, 63));
      push_item(OP_BEGIN, rnd8(), rnd8(), cnt, rnd8(), drain || ($urandom_range(0, 99) < 3), 0);
      len = (cnt > MAX_PAYLOAD) ? MAX_PAYLOAD : cnt;
      cut = len;
      if (len > 0 && $urandom_range(0, 99) < 8) cut = $urandom_range(0, len - 1);
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(0, 99) < 4) begin
            if ($urandom_range(0, 1) == 0)
               push_item(OP_UNUSED, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 1);
            else
               push_item(OP_RESPONSE, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 1);
         end
         push_item(OP_PAYLOAD, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 0);
      end
      if (cut < len) return;
      r = $urandom_range(0, 99);
      resends = (r < 65) ? 0 : (r < 90) ? 1 : 2;
      for (int i = 0; i < resends; i++) begin
         if ($urandom_range(0, 99) < 5)
            push_item(OP_PAYLOAD, rnd8(), rnd8(), 6'($urandom_range(0, 63)), rnd8(), 0, 1);
         push_item(OP_RESPONSE, rnd8(), rnd8(), 6'($urandom_range(0, 63)), RESEND_CODE, 0, 0);
      end
      close_frame();
      if ($urandom_range(0, 99) < 6) push_noise();
   endtask

   task automatic csr_write(input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= DEV_ADDR_OFFSET;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      addr_cfg = value[ADDR_WIDTH-1:0];
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || bus_words_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_WIDTH-1:0] addr_val;
      int unsigned target;
      bit paused;
      while (reset) @(negedge clock);
      csr_write(32'h7F);

      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'hFF, 0, 1);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, RESEND_CODE, 0, 1);
      push_item(OP_UNUSED, 8'hFF, 8'hFF, 6'h3F, 8'hFF, 0, 1);
      push_item(OP_BEGIN, 8'h00, 8'h00, 6'd0, 8'h00, 0, 0);
      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'h00, 0, 1);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, RESEND_CODE, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, 8'h00, 0, 0);
      push_item(OP_BEGIN, 8'hFF, 8'hFF, 6'h3F, 8'h00, 0, 0);
      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'hFF, 0, 0);
      push_item(OP_PAYLOAD, 8'hFF, 8'hFF, 6'h3F, 8'h00, 0, 0);
      push_item(OP_BEGIN, 8'h41, 8'h5A, 6'd2, 8'h00, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, RESEND_CODE, 0, 1);
      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'h80, 0, 0);
      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'h7F, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, RESEND_CODE, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, 8'd14, 0, 0);
      push_item(OP_BEGIN, 8'h01, 8'h02, 6'd1, 8'h00, 0, 0);
      push_item(OP_PAYLOAD, 8'h00, 8'h00, 6'd0, 8'hFF, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, 8'hFF, 0, 0);
      push_item(OP_BEGIN, 8'h7E, 8'h81, 6'd33, 8'h00, 0, 0);
      push_item(OP_RESPONSE, 8'h00, 8'h00, 6'd0, 8'd16, 0, 1);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: addr_val = 32'h0;
            1: addr_val = {25'($urandom_range(0, 32'h01FF_FFFF)), 7'($urandom_range(0, 127))};
            2: addr_val = 32'h1;
            default: addr_val = 32'h2A;
         endcase
         csr_write(addr_val);
         target = items_queued + ITEMS_PER_PHASE;
         paused = 0;
         while (items_queued < target) begin
            queue_frame(!paused && items_queued + ITEMS_PER_PHASE / 2 >= target);
            if (items_queued + ITEMS_PER_PHASE / 2 >= target) paused = 1;
         end
         push_item(OP_BEGIN, rnd8(), rnd8(), 6'd0, rnd8(), 0, 0);
         close_frame();
         wait_idle();
      end

      if (mismatches == 0 && bus_words_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
